// ===== sv/fsnc_pkg.sv =====
// ---------------------------------------------------------------------------
// fsnc_pkg: shared types and constants for the FAT short name converter
// Character codes, register decode and the name/result structs.
// ---------------------------------------------------------------------------
package fsnc_pkg;

   localparam int BASE_LEN_DEF = 8;
   localparam int FULL_LEN_DEF = 11;
   localparam int BUF_BYTES    = 11;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_LOW_A = 8'h61;
   localparam logic [7:0] CH_LOW_Z = 8'h7A;
   localparam logic [7:0] CASE_OFS = 8'h20;

   // register select is paddr[3]
   localparam logic REG_BASE = 1'b0;
   localparam logic REG_EXT  = 1'b1;

   typedef logic [BUF_BYTES-1:0][7:0] name_buf_type;

   // per-character strobe from the top into the name builder
   typedef struct packed {
      logic       take;
      logic [7:0] char_byte;
   } char_beat_type;

   // result fields as computed from the builder's current state
   typedef struct packed {
      logic [63:0] base_name;
      logic [23:0] ext_name;
      logic [3:0]  consumed_length;
      logic        too_long;
      logic        names_match;
   } name_result_type;

   function automatic logic [7:0] upcase(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if (c >= CH_LOW_A && c <= CH_LOW_Z) begin
         r = c - CASE_OFS;
      end
      return r;
   endfunction

   function automatic logic is_term(input logic [7:0] c);
      return (c == CH_NUL) || (c == CH_SLASH);
   endfunction

endpackage

// ===== sv/fsnc_if.sv =====
// ---------------------------------------------------------------------------
// fsnc_if: valid/ready channels for characters and short-name results
// One interface per channel direction.
// ---------------------------------------------------------------------------
interface fsnc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_byte;

   modport source (output valid, output char_byte, input ready);
   modport sink   (input valid, input char_byte, output ready);
endinterface

interface fsnc_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] base_name;
   logic [23:0] ext_name;
   logic [3:0]  consumed_length;
   logic        ended_with_slash;
   logic        too_long;
   logic        names_match;

   modport source (output valid, output base_name, output ext_name,
                   output consumed_length, output ended_with_slash,
                   output too_long, output names_match, input ready);
   modport sink   (input valid, input base_name, input ext_name,
                   input consumed_length, input ended_with_slash,
                   input too_long, input names_match, output ready);
endinterface

// ===== sv/fsnc_builder.sv =====
// ---------------------------------------------------------------------------
// fsnc_builder: short name buffer and character state
// Holds the 11-byte name, position, extension flag, count and overflow.
// ---------------------------------------------------------------------------
module fsnc_builder #(
   parameter int BASE_LEN = fsnc_pkg::BASE_LEN_DEF,
   parameter int FULL_LEN = fsnc_pkg::FULL_LEN_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  fsnc_pkg::char_beat_type   beat,
   input  logic [63:0]               entry_base,
   input  logic [23:0]               entry_ext,
   output fsnc_pkg::name_result_type result
);

   localparam logic [3:0] BasePos = 4'(BASE_LEN);
   localparam logic [3:0] FullPos = 4'(FULL_LEN);

   fsnc_pkg::name_buf_type buf_ff, buf_in;
   logic [3:0] pos_ff, pos_in;
   logic [3:0] count_ff, count_in;
   logic       in_ext_ff, in_ext_in;
   logic       ovf_ff, ovf_in;

   logic       wr_en;
   logic [7:0] wr_char;
   logic [fsnc_pkg::BUF_BYTES*8-1:0] entry_all;
   logic       mismatch;

   assign wr_char = fsnc_pkg::upcase(beat.char_byte);

   always_comb begin
      buf_in    = buf_ff;
      pos_in    = pos_ff;
      count_in  = count_ff;
      in_ext_in = in_ext_ff;
      ovf_in    = ovf_ff;
      wr_en     = 1'b0;
      if (beat.take) begin
         priority if (fsnc_pkg::is_term(beat.char_byte)) begin
            buf_in    = {fsnc_pkg::BUF_BYTES{fsnc_pkg::CH_SPACE}};
            pos_in    = '0;
            count_in  = '0;
            in_ext_in = 1'b0;
            ovf_in    = 1'b0;
         end else if (ovf_ff) begin
            // swallow until terminator
         end else if (!in_ext_ff) begin
            if (beat.char_byte == fsnc_pkg::CH_DOT) begin
               in_ext_in = 1'b1;
               pos_in    = BasePos;
               count_in  = count_ff + 4'd1;
            end else if (pos_ff < BasePos) begin
               wr_en = 1'b1;
            end else begin
               ovf_in = 1'b1;
            end
         end else begin
            if (pos_ff < FullPos) begin
               wr_en = 1'b1;
            end else begin
               ovf_in = 1'b1;
            end
         end
         if (wr_en) begin
            pos_in   = pos_ff + 4'd1;
            count_in = count_ff + 4'd1;
            for (int i = 0; i < fsnc_pkg::BUF_BYTES; i++) begin
               if (pos_ff == 4'(i)) begin
                  buf_in[i] = wr_char;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_ff    <= {fsnc_pkg::BUF_BYTES{fsnc_pkg::CH_SPACE}};
         pos_ff    <= '0;
         count_ff  <= '0;
         in_ext_ff <= 1'b0;
         ovf_ff    <= 1'b0;
      end else begin
         buf_ff    <= buf_in;
         pos_ff    <= pos_in;
         count_ff  <= count_in;
         in_ext_ff <= in_ext_in;
         ovf_ff    <= ovf_in;
      end
   end

   // compare only the first FULL_LEN bytes
   assign entry_all = {entry_ext, entry_base};

   always_comb begin
      mismatch = 1'b0;
      for (int i = 0; i < fsnc_pkg::BUF_BYTES; i++) begin
         if (i < FULL_LEN && buf_ff[i] != entry_all[8*i +: 8]) begin
            mismatch = 1'b1;
         end
      end
   end

   always_comb begin
      if (ovf_ff) begin
         result.base_name       = '0;
         result.ext_name        = '0;
         result.consumed_length = '0;
         result.too_long        = 1'b1;
         result.names_match     = 1'b0;
      end else begin
         result.base_name       = buf_ff[7:0];
         result.ext_name        = buf_ff[10:8];
         result.consumed_length = count_ff;
         result.too_long        = 1'b0;
         result.names_match     = !mismatch;
      end
   end

endmodule

// ===== sv/fat_short_name_convert_match.sv =====
// ---------------------------------------------------------------------------
// fat_short_name_convert_match: FAT 8.3 short name builder and matcher
// Streams path characters into a padded 11-byte name and compares it
// against a configured directory entry name at each terminator.
// ---------------------------------------------------------------------------
//
//  channel | dir | handshake           | beat carries
//  --------+-----+---------------------+-------------------------------------
//  req_if  | in  | valid/ready         | char_byte
//  rsp_if  | out | valid/ready         | name, length, slash, too_long, match
//  csr     | in  | APB psel/penable    | entry_name_base (0x0), _ext (0x8)
//
//  Rate: one character beat per cycle while req_if.ready is high. The name state updates
//  at the accepting edge; a terminator (0 or '/') loads the result register
//  at that edge and the result is offered on the next cycle.
//  Stalls: req_if.ready drops only while a result is held and rsp_if.ready
//  is low; the result register is the only buffer between the two sides.
//  Reset (synchronous, active high): name state to all spaces, counters and
//  flags to zero, entry name registers to zero, result register empty.
//  After overflow all characters up to the terminator are swallowed.
//
module fat_short_name_convert_match #(
   parameter int BASE_LEN = fsnc_pkg::BASE_LEN_DEF,
   parameter int FULL_LEN = fsnc_pkg::FULL_LEN_DEF
) (
   input  logic        clock,
   input  logic        reset,
   fsnc_req_if.sink    req_if,
   fsnc_rsp_if.source  rsp_if,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [63:0] pwdata,
   output logic [63:0] prdata,
   output logic        pready
);

   // ---- configuration registers ----
   logic [63:0] entry_base_ff;
   logic [23:0] entry_ext_ff;
   logic        csr_wr;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_base_ff <= '0;
         entry_ext_ff  <= '0;
      end else if (csr_wr) begin
         unique case (paddr[3])
            fsnc_pkg::REG_BASE: entry_base_ff <= pwdata;
            fsnc_pkg::REG_EXT:  entry_ext_ff  <= pwdata[23:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3])
         fsnc_pkg::REG_BASE: prdata = entry_base_ff;
         fsnc_pkg::REG_EXT:  prdata = {40'd0, entry_ext_ff};
         default:            prdata = '0;
      endcase
   end

   // ---- input handshake ----
   logic rsp_valid_ff;
   logic req_take;
   logic term_take;

   // result register frees up in the same cycle it is taken
   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign req_take     = req_if.valid && req_if.ready;
   assign term_take    = req_take && fsnc_pkg::is_term(req_if.char_byte);

   fsnc_pkg::char_beat_type   beat;
   fsnc_pkg::name_result_type cur_result;

   assign beat.take      = req_take;
   assign beat.char_byte = req_if.char_byte;

   fsnc_builder #(
      .BASE_LEN (BASE_LEN),
      .FULL_LEN (FULL_LEN)
   ) u_builder (
      .clock      (clock),
      .reset      (reset),
      .beat       (beat),
      .entry_base (entry_base_ff),
      .entry_ext  (entry_ext_ff),
      .result     (cur_result)
   );

   // ---- result register ----
   fsnc_pkg::name_result_type result_ff;
   logic                      slash_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (term_take) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // payload: snapshot of the name state as the terminator arrives
   always_ff @(posedge clock) begin
      if (term_take) begin
         result_ff <= cur_result;
         slash_ff  <= (req_if.char_byte == fsnc_pkg::CH_SLASH);
      end
   end

   assign rsp_if.valid            = rsp_valid_ff;
   assign rsp_if.base_name        = result_ff.base_name;
   assign rsp_if.ext_name         = result_ff.ext_name;
   assign rsp_if.consumed_length  = result_ff.consumed_length;
   assign rsp_if.ended_with_slash = slash_ff;
   assign rsp_if.too_long         = result_ff.too_long;
   assign rsp_if.names_match      = result_ff.names_match;

endmodule

// ===== sv/fsnc_checker.sv =====
// ---------------------------------------------------------------------------
// fsnc_checker: port-level assertions for the short name converter
// Bound onto the top level; sees only its ports.
// ---------------------------------------------------------------------------
module fsnc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [7:0]  req_char,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [63:0] rsp_base,
   input logic [3:0]  rsp_len,
   input logic        rsp_too_long,
   input logic        rsp_match
);

   // a result held back stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   // a new result only follows an accepted terminator
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |->
         $past(req_valid && req_ready && fsnc_pkg::is_term(req_char)))
      else $error("result without terminator");

   // overflow result carries no name, no length and no match
   a_overflow: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_too_long |-> rsp_base == '0 && rsp_len == '0 && !rsp_match)
      else $error("overflow result not cleared");

   // a name holds at most 8 + dot + 3 characters
   a_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_len <= 4'd12)
      else $error("consumed length out of range");

   // nothing is offered right after reset
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind fat_short_name_convert_match fsnc_checker u_fsnc_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_if.valid),
   .req_ready    (req_if.ready),
   .req_char     (req_if.char_byte),
   .rsp_valid    (rsp_if.valid),
   .rsp_ready    (rsp_if.ready),
   .rsp_base     (rsp_if.base_name),
   .rsp_len      (rsp_if.consumed_length),
   .rsp_too_long (rsp_if.too_long),
   .rsp_match    (rsp_if.names_match)
);
